@@ rtl/core/dpss_pkg.sv @@
// ----------------------------------------------------------------------------
// dpss_pkg: drive power-state sequencer package
// Item types, power-state codes, control word values and mode codes shared
// by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpss_pkg;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETTLE_POLLS = 1'b0,
      CSR_OFFSET_COUNT = 1'b1
   } csr_idx_type;

   // decoded power states, A..H, and unknown
   localparam logic [3:0] PS_A       = 4'd0;
   localparam logic [3:0] PS_B       = 4'd1;
   localparam logic [3:0] PS_C       = 4'd2;
   localparam logic [3:0] PS_D       = 4'd3;
   localparam logic [3:0] PS_E       = 4'd4;
   localparam logic [3:0] PS_F       = 4'd5;
   localparam logic [3:0] PS_G       = 4'd6;
   localparam logic [3:0] PS_H       = 4'd7;
   localparam logic [3:0] PS_UNKNOWN = 4'd8;

   // status masks and match patterns
   localparam logic [15:0] MASK_LO   = 16'h004F;
   localparam logic [15:0] MASK_HI   = 16'h006F;
   localparam logic [15:0] PAT_A     = 16'h0000;
   localparam logic [15:0] PAT_B     = 16'h0040;
   localparam logic [15:0] PAT_C     = 16'h0021;
   localparam logic [15:0] PAT_D     = 16'h0023;
   localparam logic [15:0] PAT_E     = 16'h0027;
   localparam logic [15:0] PAT_F     = 16'h0007;
   localparam logic [15:0] PAT_G     = 16'h000F;
   localparam logic [15:0] PAT_H     = 16'h0008;

   // control words
   localparam logic [7:0] CW_NONE     = 8'h00;
   localparam logic [7:0] CW_SHUTDOWN = 8'h06;
   localparam logic [7:0] CW_SWITCHON = 8'h07;
   localparam logic [7:0] CW_ENABLE   = 8'h0F;
   localparam logic [7:0] CW_FAULTRST = 8'h80;

   // displayed modes
   localparam logic [7:0] MODE_CSP = 8'h08;
   localparam logic [7:0] MODE_CSV = 8'h09;
   localparam logic [7:0] MODE_OFS = 8'h10;

   // command
   localparam logic FUNC_ENABLE  = 1'b0;
   localparam logic FUNC_DISABLE = 1'b1;

   // register reset values
   localparam logic [7:0]         SETTLE_POLLS_RST = 8'd20;
   localparam logic signed [31:0] OFFSET_COUNT_RST = 32'sd0;

   typedef struct packed {
      logic               func;
      logic [15:0]        drive_status;
      logic [7:0]         display_mode;
      logic signed [31:0] actual_position;
   } req_type;

   typedef struct packed {
      logic               control_write;
      logic [7:0]         control_word;
      logic               target_pos_write;
      logic signed [31:0] target_position;
      logic               target_vel_zero;
      logic [3:0]         power_state;
      logic               reached;
      logic               unknown_status;
   } rsp_type;

   // configuration seen by the decoder
   typedef struct packed {
      logic [7:0]         settle_polls;
      logic signed [31:0] offset_count;
   } cfg_type;

   // settle counter update from the decoder
   typedef struct packed {
      logic       upd;
      logic [7:0] value;
   } settle_type;

endpackage

`default_nettype wire

@@ rtl/core/dpss_csr.sv @@
// ----------------------------------------------------------------------------
// dpss_csr: configuration registers
// Holds the settle poll count and the position offset; plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dpss_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [dpss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dpss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output dpss_pkg::cfg_type                        cfg
);

   logic [7:0]         settle_polls_ff, settle_polls_in;
   logic signed [31:0] offset_count_ff, offset_count_in;

   // register write decode
   always_comb begin
      settle_polls_in = settle_polls_ff;
      offset_count_in = offset_count_ff;
      if (csr_we) begin
         unique case (dpss_pkg::csr_idx_type'(csr_index))
            dpss_pkg::CSR_SETTLE_POLLS: settle_polls_in = csr_wdata[7:0];
            dpss_pkg::CSR_OFFSET_COUNT: offset_count_in = signed'(csr_wdata[31:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_polls_ff <= dpss_pkg::SETTLE_POLLS_RST;
         offset_count_ff <= dpss_pkg::OFFSET_COUNT_RST;
      end else begin
         settle_polls_ff <= settle_polls_in;
         offset_count_ff <= offset_count_in;
      end
   end

   assign cfg.settle_polls = settle_polls_ff;
   assign cfg.offset_count = offset_count_ff;

endmodule

`default_nettype wire

@@ rtl/core/dpss_decode.sv @@
// ----------------------------------------------------------------------------
// dpss_decode: status decode and step logic
// Decodes the status word into a power state and works out the control,
// target writes, reached flag and settle counter update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module dpss_decode (
   input  wire dpss_pkg::req_type  item,
   input  wire dpss_pkg::cfg_type  cfg,
   input  wire logic [7:0]         settle_left,
   output dpss_pkg::rsp_type       rsp,
   output dpss_pkg::settle_type    settle
);

   logic [15:0] s_lo;
   logic [15:0] s_hi;
   logic [3:0]  ps;
   logic [7:0]  settle_dec;
   logic        disable_cmd;

   assign s_lo        = item.drive_status & dpss_pkg::MASK_LO;
   assign s_hi        = item.drive_status & dpss_pkg::MASK_HI;
   assign disable_cmd = (item.func == dpss_pkg::FUNC_DISABLE);

   // saturating count-down
   assign settle_dec = (settle_left != 8'd0) ? settle_left - 8'd1 : 8'd0;

   // first match wins
   always_comb begin
      priority if (s_lo == dpss_pkg::PAT_A) ps = dpss_pkg::PS_A;
      else if (s_lo == dpss_pkg::PAT_B)     ps = dpss_pkg::PS_B;
      else if (s_hi == dpss_pkg::PAT_C)     ps = dpss_pkg::PS_C;
      else if (s_hi == dpss_pkg::PAT_D)     ps = dpss_pkg::PS_D;
      else if (s_hi == dpss_pkg::PAT_E)     ps = dpss_pkg::PS_E;
      else if (s_hi == dpss_pkg::PAT_F)     ps = dpss_pkg::PS_F;
      else if (s_lo == dpss_pkg::PAT_G)     ps = dpss_pkg::PS_G;
      else if (s_lo == dpss_pkg::PAT_H)     ps = dpss_pkg::PS_H;
      else                                  ps = dpss_pkg::PS_UNKNOWN;
   end

   // step toward the commanded state
   always_comb begin
      rsp                  = '0;
      rsp.power_state      = ps;
      rsp.unknown_status   = (ps == dpss_pkg::PS_UNKNOWN);
      settle.upd           = 1'b0;
      settle.value         = settle_dec;
      unique case (ps)
         dpss_pkg::PS_B: begin
            rsp.control_write = 1'b1;
            rsp.control_word  = dpss_pkg::CW_SHUTDOWN;
         end
         dpss_pkg::PS_C: begin
            rsp.control_write = 1'b1;
            rsp.control_word  = dpss_pkg::CW_SWITCHON;
         end
         dpss_pkg::PS_D: begin
            if (disable_cmd) begin
               rsp.reached = 1'b1;
            end else begin
               rsp.control_write = 1'b1;
               rsp.control_word  = dpss_pkg::CW_ENABLE;
               settle.upd        = 1'b1;
               settle.value      = cfg.settle_polls;
               priority if (item.display_mode == dpss_pkg::MODE_CSP) begin
                  rsp.target_pos_write = 1'b1;
                  rsp.target_position  = item.actual_position;
               end else if (item.display_mode == dpss_pkg::MODE_CSV) begin
                  rsp.target_vel_zero = 1'b1;
               end else if (item.display_mode == dpss_pkg::MODE_OFS) begin
                  rsp.target_pos_write = 1'b1;
                  rsp.target_position  = cfg.offset_count;
               end else begin
                  rsp.target_pos_write = 1'b1;
                  rsp.target_position  = item.actual_position;
                  rsp.target_vel_zero  = 1'b1;
               end
            end
         end
         dpss_pkg::PS_E: begin
            if (disable_cmd) begin
               rsp.control_write = 1'b1;
               rsp.control_word  = dpss_pkg::CW_SHUTDOWN;
            end else begin
               settle.upd  = 1'b1;
               rsp.reached = (settle_dec == 8'd0);
            end
         end
         dpss_pkg::PS_F, dpss_pkg::PS_G: begin
            rsp.control_write = 1'b1;
            rsp.control_word  = dpss_pkg::CW_NONE;
         end
         dpss_pkg::PS_H: begin
            rsp.control_write = 1'b1;
            rsp.control_word  = dpss_pkg::CW_FAULTRST;
         end
         default: ;  // A and unknown: no writes
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/drive_power_state_sequencer.sv @@
// Items pass through the input register, then the result register.
// Throughput: one item per cycle unless rsp_stall holds a result; the settle counter updates
// as each item leaves the input register. A waiting result keeps the next item in the input register.
// Reset (synchronous, active high): pipeline empty, settle counter 0,
// settle_polls 20, offset_count 0.
// ----------------------------------------------------------------------------
// drive_power_state_sequencer: drive power-state sequencer top level
// Decodes polled drive status and issues the control and target writes that
// step the drive toward operation enabled or switched on.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_power_state_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire dpss_pkg::req_type                 req_data,
   // result items
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output dpss_pkg::rsp_type                      rsp_data,
   // configuration
   input  wire logic                              csr_we,
   input  wire logic [dpss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dpss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dpss_pkg::cfg_type     cfg;
   dpss_pkg::rsp_type     step_rsp;
   dpss_pkg::settle_type  settle;

   logic                  in_valid_ff, in_valid_in;
   dpss_pkg::req_type     in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   dpss_pkg::rsp_type     out_data_ff;
   logic [7:0]            settle_left_ff, settle_left_in;
   logic                  out_free;
   logic                  advance;
   logic                  accept;

   dpss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dpss_decode u_decode (
      .item        (in_data_ff),
      .cfg         (cfg),
      .settle_left (settle_left_ff),
      .rsp         (step_rsp),
      .settle      (settle)
   );

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in    = accept || (in_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && rsp_stall);
   assign settle_left_in = (advance && settle.upd) ? settle.value : settle_left_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         settle_left_ff <= 8'd0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         settle_left_ff <= settle_left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

@@ test/tb_drive_power_state_sequencer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drive_power_state_sequencer: self-checking bench for the sequencer
// Walks a table of directed polls, then random poll sequences under several
// register settings. Each accepted item is run through a local model of the
// decode and settle counter, and every result item is checked field by field.
// ----------------------------------------------------------------------------

module tb_drive_power_state_sequencer;
   import dpss_pkg::*;

   // one poll, with a hand-written expectation where it is obvious
   typedef struct {
      req_type poll;
      bit      typed;
      rsp_type want;
   } poll_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // local copy of the registers and the settle counter
   logic [7:0]            cfg_settle_polls = SETTLE_POLLS_RST;
   logic signed [31:0]    cfg_offset_count = OFFSET_COUNT_RST;
   logic [7:0]            settle_remaining = 8'd0;

   poll_row_type          poll_notes [$];
   rsp_type               pending_replies [$];
   poll_row_type          poll_tbl [25];
   int                    polls_taken = 0;
   int                    polls_sent = 0;
   int                    replies_taken = 0;
   int                    mismatches = 0;
   bit                    steady = 1'b0;

   drive_power_state_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // hard stop in case the block hangs
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
   endtask

   task automatic check_reply(input rsp_type got, input rsp_type want);
      if (got.control_write !== want.control_write)
         report_mismatch("control_write", got.control_write, want.control_write);
      if (got.control_word !== want.control_word)
         report_mismatch("control_word", got.control_word, want.control_word);
      if (got.target_pos_write !== want.target_pos_write)
         report_mismatch("target_pos_write", got.target_pos_write, want.target_pos_write);
      if (got.target_position !== want.target_position)
         report_mismatch("target_position", got.target_position, want.target_position);
      if (got.target_vel_zero !== want.target_vel_zero)
         report_mismatch("target_vel_zero", got.target_vel_zero, want.target_vel_zero);
      if (got.power_state !== want.power_state)
         report_mismatch("power_state", got.power_state, want.power_state);
      if (got.reached !== want.reached)
         report_mismatch("reached", got.reached, want.reached);
      if (got.unknown_status !== want.unknown_status)
         report_mismatch("unknown_status", got.unknown_status, want.unknown_status);
   endtask

   // decode the status, step toward the commanded state, track the settle count
   function automatic rsp_type predict_poll(input req_type poll);
      rsp_type    r;
      logic [3:0] ps;
      r = '0;
      if      ((poll.drive_status & MASK_LO) == PAT_A) ps = PS_A;
      else if ((poll.drive_status & MASK_LO) == PAT_B) ps = PS_B;
      else if ((poll.drive_status & MASK_HI) == PAT_C) ps = PS_C;
      else if ((poll.drive_status & MASK_HI) == PAT_D) ps = PS_D;
      else if ((poll.drive_status & MASK_HI) == PAT_E) ps = PS_E;
      else if ((poll.drive_status & MASK_HI) == PAT_F) ps = PS_F;
      else if ((poll.drive_status & MASK_LO) == PAT_G) ps = PS_G;
      else if ((poll.drive_status & MASK_LO) == PAT_H) ps = PS_H;
      else                                             ps = PS_UNKNOWN;
      r.power_state    = ps;
      r.unknown_status = (ps == PS_UNKNOWN);
      case (ps)
         PS_B: begin
            r.control_write = 1'b1;
            r.control_word  = CW_SHUTDOWN;
         end
         PS_C: begin
            r.control_write = 1'b1;
            r.control_word  = CW_SWITCHON;
         end
         PS_D: begin
            if (poll.func == FUNC_DISABLE) begin
               r.reached = 1'b1;
            end else begin
               r.control_write  = 1'b1;
               r.control_word   = CW_ENABLE;
               settle_remaining = cfg_settle_polls;
               case (poll.display_mode)
                  MODE_CSP: begin
                     r.target_pos_write = 1'b1;
                     r.target_position  = poll.actual_position;
                  end
                  MODE_CSV: begin
                     r.target_vel_zero = 1'b1;
                  end
                  MODE_OFS: begin
                     r.target_pos_write = 1'b1;
                     r.target_position  = cfg_offset_count;
                  end
                  default: begin
                     r.target_pos_write = 1'b1;
                     r.target_position  = poll.actual_position;
                     r.target_vel_zero  = 1'b1;
                  end
               endcase
            end
         end
         PS_E: begin
            if (poll.func == FUNC_DISABLE) begin
               r.control_write = 1'b1;
               r.control_word  = CW_SHUTDOWN;
            end else begin
               // counter stops at zero
               if (settle_remaining != 8'd0) settle_remaining = settle_remaining - 8'd1;
               r.reached = (settle_remaining == 8'd0);
            end
         end
         PS_F, PS_G: begin
            r.control_write = 1'b1;
            r.control_word  = CW_NONE;
         end
         PS_H: begin
            r.control_write = 1'b1;
            r.control_word  = CW_FAULTRST;
         end
         default: ;
      endcase
      return r;
   endfunction

   // status word for a given state, with random don't-care bits; unknown gives raw noise
   function automatic req_type random_poll(input logic [3:0] ps, input logic fn);
      req_type     p;
      logic [15:0] fill;
      fill   = 16'($urandom);
      p.func = fn;
      case (ps)
         PS_A:    p.drive_status = (fill & ~MASK_LO) | PAT_A;
         PS_B:    p.drive_status = (fill & ~MASK_LO) | PAT_B;
         PS_C:    p.drive_status = (fill & ~MASK_HI) | PAT_C;
         PS_D:    p.drive_status = (fill & ~MASK_HI) | PAT_D;
         PS_E:    p.drive_status = (fill & ~MASK_HI) | PAT_E;
         PS_F:    p.drive_status = (fill & ~MASK_HI) | PAT_F;
         PS_G:    p.drive_status = (fill & ~MASK_LO) | PAT_G;
         PS_H:    p.drive_status = (fill & ~MASK_LO) | PAT_H;
         default: p.drive_status = fill;
      endcase
      case ($urandom_range(0, 3))
         0:       p.display_mode = MODE_CSP;
         1:       p.display_mode = MODE_CSV;
         2:       p.display_mode = MODE_OFS;
         default: p.display_mode = 8'($urandom);
      endcase
      p.actual_position = $urandom;
      return p;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_poll(input req_type poll, input bit typed, input rsp_type want);
      poll_row_type note;
      int           gap;
      int           seen;
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      note = '{poll, typed, want};
      poll_notes.push_back(note);
      seen = polls_taken;
      req_valid <= 1'b1;
      req_data  <= poll;
      do @(negedge clock); while (polls_taken == seen);
      polls_sent++;
   endtask

   // registers change only with the pipeline empty
   task automatic load_settings(input logic [7:0] settle, input logic signed [31:0] offset);
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SETTLE_POLLS;
      csr_wdata <= {24'd0, settle};
      @(negedge clock);
      cfg_settle_polls = settle;
      csr_index <= CSR_OFFSET_COUNT;
      csr_wdata <= offset;
      @(negedge clock);
      cfg_offset_count = offset;
      csr_we <= 1'b0;
   endtask

   task automatic run_random_phase(input int quota);
      int         start;
      int         kind;
      logic [3:0] ps;
      start = polls_sent;
      // one full settle: enable from switched on, then hold in E past the count
      steady = 1'b0;
      push_poll(random_poll(PS_D, FUNC_ENABLE), 1'b0, '0);
      repeat (int'(cfg_settle_polls) + 2) push_poll(random_poll(PS_E, FUNC_ENABLE), 1'b0, '0);
      while (polls_sent - start < quota) begin
         steady = ($urandom_range(0, 3) == 0);
         kind   = $urandom_range(0, 9);
         if (kind <= 5) begin
            // power-up walk toward operation enabled
            for (ps = 4'($urandom_range(PS_A, PS_D)); ps <= PS_D; ps++)
               push_poll(random_poll(ps, FUNC_ENABLE), 1'b0, '0);
            repeat ($urandom_range(0, 8))
               push_poll(random_poll(PS_E, FUNC_ENABLE), 1'b0, '0);
         end else if (kind <= 7) begin
            // disable from wherever the drive is
            repeat ($urandom_range(1, 5))
               push_poll(random_poll(4'($urandom_range(PS_A, PS_H)), FUNC_DISABLE), 1'b0, '0);
         end else if (kind == 8) begin
            // fault states with either command
            repeat ($urandom_range(1, 3))
               push_poll(random_poll(4'($urandom_range(PS_F, PS_H)), 1'($urandom)),
                         1'b0, '0);
         end else begin
            // raw status words
            repeat ($urandom_range(1, 4))
               push_poll(random_poll(PS_UNKNOWN, 1'($urandom)), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;
   endtask

   // result side: random stall before each item
   initial begin
      int hold;
      int seen;
      rsp_stall = 1'b0;
      forever begin
         hold = steady ? 0 : $urandom_range(0, 14);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         seen = replies_taken;
         do @(negedge clock); while (replies_taken == seen);
      end
   end

   // both handshakes sampled at the rising edge
   always @(posedge clock) begin
      poll_row_type note;
      rsp_type      guess;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0)
               report_mismatch("result with nothing expected", rsp_data.power_state, 0);
            else
               check_reply(rsp_data, pending_replies.pop_front());
            replies_taken++;
         end
         if (req_valid && !req_stall) begin
            note  = poll_notes.pop_front();
            guess = predict_poll(req_data);
            pending_replies.push_back(note.typed ? note.want : guess);
            polls_taken++;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_SETTLE_POLLS;
      csr_wdata = '0;

      // directed polls at reset settings (settle 20, offset 0, counter 0)
      poll_tbl = '{
         '{'{FUNC_ENABLE,  16'h0000, 8'h08, 32'sd0}, 1'b1,
           '{1'b0, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_A, 1'b0, 1'b0}},
         '{'{FUNC_DISABLE, 16'hFFB0, 8'hFF, 32'sh7FFFFFFF}, 1'b1,
           '{1'b0, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_A, 1'b0, 1'b0}},
         '{'{FUNC_ENABLE,  16'h0040, 8'h00, 32'sd0}, 1'b1,
           '{1'b1, CW_SHUTDOWN, 1'b0, 32'sd0, 1'b0, PS_B, 1'b0, 1'b0}},
         '{'{FUNC_ENABLE,  16'h0021, 8'h00, 32'sd0}, 1'b1,
           '{1'b1, CW_SWITCHON, 1'b0, 32'sd0, 1'b0, PS_C, 1'b0, 1'b0}},
         '{'{FUNC_DISABLE, 16'h0023, 8'h00, 32'sd0}, 1'b1,
           '{1'b0, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_D, 1'b1, 1'b0}},
         '{'{FUNC_DISABLE, 16'h0027, 8'h00, 32'sd0}, 1'b1,
           '{1'b1, CW_SHUTDOWN, 1'b0, 32'sd0, 1'b0, PS_E, 1'b0, 1'b0}},
         // counter still zero from reset
         '{'{FUNC_ENABLE,  16'h0027, 8'h00, 32'sd0}, 1'b1,
           '{1'b0, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_E, 1'b1, 1'b0}},
         '{'{FUNC_ENABLE,  16'h0023, MODE_CSP, 32'sh7FFFFFFF}, 1'b1,
           '{1'b1, CW_ENABLE, 1'b1, 32'sh7FFFFFFF, 1'b0, PS_D, 1'b0, 1'b0}},
         '{'{FUNC_ENABLE,  16'hFF27, 8'h00, 32'sd0}, 1'b0, '0},
         '{'{FUNC_ENABLE,  16'h0023, MODE_CSV, 32'sh80000000}, 1'b1,
           '{1'b1, CW_ENABLE, 1'b0, 32'sd0, 1'b1, PS_D, 1'b0, 1'b0}},
         '{'{FUNC_ENABLE,  16'h0023, MODE_OFS, 32'sh12345678}, 1'b1,
           '{1'b1, CW_ENABLE, 1'b1, 32'sd0, 1'b0, PS_D, 1'b0, 1'b0}},
         '{'{FUNC_ENABLE,  16'h0023, 8'hFF, 32'sh80000000}, 1'b1,
           '{1'b1, CW_ENABLE, 1'b1, 32'sh80000000, 1'b1, PS_D, 1'b0, 1'b0}},
         '{'{FUNC_ENABLE,  16'h0023, 8'h00, -32'sd1}, 1'b0, '0},
         '{'{FUNC_ENABLE,  16'h0007, 8'h00, 32'sd0}, 1'b1,
           '{1'b1, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_F, 1'b0, 1'b0}},
         '{'{FUNC_DISABLE, 16'hFF87, 8'h00, 32'sd0}, 1'b0, '0},
         '{'{FUNC_ENABLE,  16'h000F, 8'h00, 32'sd0}, 1'b1,
           '{1'b1, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_G, 1'b0, 1'b0}},
         '{'{FUNC_DISABLE, 16'hFFAF, 8'h00, 32'sd0}, 1'b0, '0},
         '{'{FUNC_ENABLE,  16'h0008, 8'h00, 32'sd0}, 1'b1,
           '{1'b1, CW_FAULTRST, 1'b0, 32'sd0, 1'b0, PS_H, 1'b0, 1'b0}},
         '{'{FUNC_DISABLE, 16'hFFA8, 8'h00, 32'sd0}, 1'b0, '0},
         // status matching no state
         '{'{FUNC_ENABLE,  16'hFFFF, 8'h00, 32'sd0}, 1'b1,
           '{1'b0, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_UNKNOWN, 1'b0, 1'b1}},
         '{'{FUNC_DISABLE, 16'h0001, 8'h00, 32'sd0}, 1'b1,
           '{1'b0, CW_NONE, 1'b0, 32'sd0, 1'b0, PS_UNKNOWN, 1'b0, 1'b1}},
         '{'{FUNC_DISABLE, 16'h0040, 8'h00, 32'sd0}, 1'b0, '0},
         '{'{FUNC_DISABLE, 16'hFFA1, 8'h00, 32'sd0}, 1'b0, '0},
         '{'{FUNC_ENABLE,  16'hFFA7, 8'h00, 32'sd0}, 1'b0, '0},
         '{'{FUNC_DISABLE, 16'hFFA3, 8'h00, 32'sd0}, 1'b0, '0}
      };

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (poll_tbl[i]) push_poll(poll_tbl[i].poll, poll_tbl[i].typed, poll_tbl[i].want);
      req_valid <= 1'b0;

      // register extremes first, then random settings; zero settle reaches at once
      load_settings(8'd0, 32'sh7FFFFFFF);
      run_random_phase(60);
      load_settings(8'd255, 32'sh80000000);
      run_random_phase(60);
      load_settings(8'd1, -32'sd1);
      run_random_phase(60);
      load_settings(8'($urandom_range(2, 8)), $urandom);
      run_random_phase(60);
      load_settings(8'($urandom_range(0, 12)), $urandom);
      run_random_phase(60);

      // let the pipeline empty, then allow for any stray result
      for (int n = 0; n < 2000 && pending_replies.size() != 0; n++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (pending_replies.size() != 0)
         report_mismatch("results never arrived", pending_replies.size(), 0);

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
